[design/cu_pkg.sv]
// shared types and constants for the combination unranker
`timescale 1ns / 1ps
package cu_pkg;
	// saturated binomial value: 33 bits, 2^32 means "2^32 or more"
	localparam int BW = 33;
	typedef logic [BW-1:0] binom_t;

	// configuration register indexes
	localparam logic CFG_SET_N  = 1'b0;
	localparam logic CFG_PICK_K = 1'b1;

	// back end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_EMIT
	} bk_state_t;
endpackage

[design/cu_front.sv]
// input stage and short queue of ranks with the configuration captured per item
`timescale 1ns / 1ps
module cu_front
	import cu_pkg::*;
#(
	parameter int NW = 7,
	parameter int KW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [31:0]   in_rank,
	input  logic [NW-1:0] n_cfg,
	input  logic [KW-1:0] k_cfg,
	input  logic          bad_cfg,
	output logic          q_valid,
	input  logic          q_ready,
	output logic [31:0]   q_rank,
	output logic [NW-1:0] q_n,
	output logic [KW-1:0] q_k,
	output logic          q_bad
);
	// two-entry queue
	logic [31:0]   rank_q [2];
	logic [NW-1:0] n_q [2];
	logic [KW-1:0] k_q [2];
	logic          bad_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	logic          push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_rank   = rank_q[rp_q];
	assign q_n      = n_q[rp_q];
	assign q_k      = k_q[rp_q];
	assign q_bad    = bad_q[rp_q];

	// pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			rank_q[wp_q] <= in_rank;
			n_q[wp_q]    <= n_cfg;
			k_q[wp_q]    <= k_cfg;
			bad_q[wp_q]  <= bad_cfg;
		end
	end
endmodule

[design/cu_back.sv]
// unranking sequencer: range check then candidate walk with a binomial table
`timescale 1ns / 1ps
module cu_back
	import cu_pkg::*;
#(
	parameter int MAX_N = 64,
	parameter int MAX_K = 16,
	parameter int NW = 7,
	parameter int KW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [31:0]   q_rank,
	input  logic [NW-1:0] q_n,
	input  logic [KW-1:0] q_k,
	input  logic          q_bad,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [5:0]    out_element_index,
	output logic [3:0]    out_position,
	output logic          out_last,
	output logic          out_error
);
	// binomial table, saturated at 2^32
	function automatic binom_t binom(input int m, input int j);
		binom_t t [MAX_N+1][MAX_K+1];
		logic [BW:0] s;
		for (int a = 0; a <= MAX_N; a++) begin
			t[a][0] = binom_t'(1);
			for (int b = 1; b <= MAX_K; b++) begin
				if (a == 0) t[a][b] = '0;
				else begin
					s = {1'b0, t[a-1][b]} + {1'b0, t[a-1][b-1]};
					t[a][b] = (s > (BW+1)'(64'h1_0000_0000)) ?
						binom_t'(64'h1_0000_0000) : s[BW-1:0];
				end
			end
		end
		return t[m][j];
	endfunction

	localparam int TN = MAX_N + 1;
	localparam int TK = MAX_K + 1;
	binom_t tbl [TN][TK];
	for (genvar gm = 0; gm < TN; gm++) begin : g_m
		for (genvar gj = 0; gj < TK; gj++) begin : g_j
			assign tbl[gm][gj] = binom(gm, gj);
		end
	end

	bk_state_t     st_q, st_d;
	logic [31:0]   r_q;
	logic [NW-1:0] n_q, x_q;
	logic [KW-1:0] k_q, i_q;
	logic          err_q;
	binom_t        c_q;
	logic [NW-1:0] ld_m;
	logic [KW-1:0] ld_j;

	// table lookup is registered to keep compare path short
	always_ff @(posedge clk) begin
		c_q <= tbl[ld_m][ld_j];
	end

	logic [NW-1:0] m_walk;
	logic [KW-1:0] j_walk;
	assign m_walk = n_q - NW'(1) - x_q;
	assign j_walk = k_q - KW'(1) - i_q;

	// next state and lookup address
	always_comb begin
		st_d    = st_q;
		q_ready = 1'b0;
		ld_m    = m_walk;
		ld_j    = j_walk;
		case (st_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				ld_m    = q_n;
				ld_j    = q_k;
				if (q_valid) st_d = ST_CHECK;
			end
			ST_CHECK: begin
				st_d = err_q || ({1'b0, r_q} >= c_q) ? ST_EMIT : ST_WALK;
			end
			ST_WALK: begin
				if (x_q == n_q - NW'(1) || {1'b0, r_q} < c_q) st_d = ST_EMIT;
				// look ahead to the next candidate
				ld_m = n_q - NW'(2) - x_q;
			end
			ST_EMIT: begin
				if (out_ready) begin
					if (err_q || i_q == k_q - KW'(1)) st_d = ST_IDLE;
					else st_d = ST_WALK;
				end
				ld_m = n_q - NW'(2) - x_q;
				ld_j = j_walk - KW'(1);
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				r_q   <= q_rank;
				n_q   <= q_n;
				k_q   <= q_k;
				err_q <= q_bad;
				x_q   <= '0;
				i_q   <= '0;
			end
			ST_CHECK: begin
				if ({1'b0, r_q} >= c_q) err_q <= 1'b1;
			end
			ST_WALK: begin
				if (!(x_q == n_q - NW'(1) || {1'b0, r_q} < c_q)) begin
					r_q <= r_q - c_q[31:0];
					x_q <= x_q + NW'(1);
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					x_q <= x_q + NW'(1);
					i_q <= i_q + KW'(1);
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = (st_q == ST_EMIT);
	assign out_element_index = err_q ? 6'd0 : x_q[5:0];
	assign out_position      = err_q ? 4'd0 : i_q[3:0];
	assign out_last          = err_q || (i_q == k_q - KW'(1));
	assign out_error         = err_q;
endmodule

[design/combination_unranker_core.sv]
// top level of the combination unranker
//   channel | dir | payload
//   s_axis  | in  | tdata: rank[31:0]
//   m_axis  | out | tdata: element_index[5:0], position[9:6]; tuser: error; tlast
//   cfg     | in  | index 0 n (elements in the set), 1 k (elements chosen)
// each rank first gets a range check, then for each element the walk tries
// candidates one by one, each with a single table lookup and compare, and then
// emits the element, holding it until m_axis_tready.
// a two-entry queue holds ranks while the sequencer is busy.
// reset sets n = 1, k = 1 and empties the queue.
`timescale 1ns / 1ps
module combination_unranker_core
	import cu_pkg::*;
#(
	parameter int MAX_N_TOTAL = 64,
	parameter int MAX_K_PICK = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // rank
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // element_index[5:0], position[9:6], zeros
	output logic        m_axis_tuser,  // error
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	logic [6:0] n_q;
	logic [4:0] k_q;
	logic       bad;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 7'd1;
			k_q <= 5'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SET_N:  n_q <= cfg_data;
				CFG_PICK_K: k_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// size checks
	assign bad = (k_q == 5'd0) || ({2'b0, k_q} > n_q) ||
		(32'(n_q) > MAX_N_TOTAL) || (32'(k_q) > MAX_K_PICK);

	logic        qv, qr, qbad;
	logic [31:0] qrank;
	logic [6:0]  qn;
	logic [4:0]  qk;
	logic [5:0]  ei;
	logic [3:0]  pos;

	cu_front #(.NW(7), .KW(5)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_rank(s_axis_tdata),
		.n_cfg(n_q), .k_cfg(k_q), .bad_cfg(bad),
		.q_valid(qv), .q_ready(qr), .q_rank(qrank), .q_n(qn), .q_k(qk), .q_bad(qbad)
	);

	cu_back #(.MAX_N(MAX_N_TOTAL), .MAX_K(MAX_K_PICK), .NW(7), .KW(5)) u_back (
		.clk, .arst_n,
		.q_valid(qv), .q_ready(qr), .q_rank(qrank), .q_n(qn), .q_k(qk), .q_bad(qbad),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_element_index(ei), .out_position(pos),
		.out_last(m_axis_tlast), .out_error(m_axis_tuser)
	);

	assign m_axis_tdata = {6'd0, pos, ei};
endmodule
